// ===== hdl/sdws_pkg.sv =====
// ----------------------------------------------------------------------------
// sdws_pkg
// Types, widths, register indexes and reset values shared by the
// straight-drive wheel synchronizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdws_pkg;

    // fixed-point formats
    localparam int DISTANCE_BITS  = 32;
    localparam int DUTY_FRAC_BITS = 8;
    localparam int DUTY_INT_W     = 8;
    localparam int DUTY_W         = DUTY_INT_W + DUTY_FRAC_BITS;
    localparam int SPEED_W        = 16;
    localparam int GAIN_W         = 16;
    localparam int GAIN_FRAC      = 12;
    localparam int PERIOD_W       = 16;
    localparam int DIST_FRAC      = 12;
    localparam int STEP_SHIFT     = 9;
    localparam int TCM_W          = 14;
    localparam int TARGET_W       = 18;
    localparam int MM_W           = 20;

    // serial datapath widths
    localparam int PROD_W  = SPEED_W + DUTY_W;
    localparam int CORR_W  = GAIN_W + DUTY_W - GAIN_FRAC;
    localparam int ACC_X_W = CORR_W + 2;
    localparam int DSUM_W  = SPEED_W + 1;
    localparam int DPROD_W = DSUM_W + PERIOD_W;
    localparam int STEP_W  = DPROD_W - STEP_SHIFT;
    localparam int GOAL_W  = TARGET_W + DIST_FRAC;
    localparam int CMP_W   = (DISTANCE_BITS > GOAL_W) ? DISTANCE_BITS : GOAL_W;
    localparam int CNT_W   = $clog2(DUTY_W);
    localparam int DCNT_W  = $clog2(PERIOD_W + 1);

    localparam int TARGET_OFFSET_MM = 50;
    localparam int MM_PER_CM        = 10;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SPEED_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SPEED_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_SPEED_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_SPEED_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_GAIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD    = 3'd7;

    localparam logic [DUTY_INT_W-1:0] RST_DUTY_MIN   = 8'd0;
    localparam logic [DUTY_INT_W-1:0] RST_DUTY_MAX   = 8'd255;
    localparam logic [SPEED_W-1:0]    RST_SPEED_LOW  = 16'd0;
    localparam logic [SPEED_W-1:0]    RST_SPEED_HIGH = 16'd16000;
    localparam logic [GAIN_W-1:0]     RST_GAIN       = 16'd410;
    localparam logic [PERIOD_W-1:0]   RST_PERIOD     = 16'd3277;

    typedef struct packed {
        logic               req_type;
        logic [TCM_W-1:0]   target_cm;
        logic [SPEED_W-1:0] velocity_right;
        logic [SPEED_W-1:0] velocity_left;
    } sdws_req_t;

    typedef struct packed {
        logic [DUTY_INT_W-1:0] duty_left;
        logic [DUTY_INT_W-1:0] duty_right;
        logic                  moving;
        logic                  done_res;
        logic [MM_W-1:0]       distance_mm;
    } sdws_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_ERR,
        ST_GAIN,
        ST_FIN
    } sdws_state_t;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_IGNORE,
        KIND_RUN
    } sdws_kind_t;

endpackage

`default_nettype wire

// ===== hdl/straight_drive_wheel_sync.sv =====
// ----------------------------------------------------------------------------
// straight_drive_wheel_sync
// Proportional left/right duty balancing and distance tracking for a
// differential drive, one result beat per request beat.
// ----------------------------------------------------------------------------
// A start beat loads the target (cm * 10 + 50 mm), clears the distance and
// sets both duties to duty_min; a velocity sample beat maps both wheel speeds
// to duties, applies the gain-scaled difference, clamps, and integrates the
// mean speed into the distance. A start beat or a sample while idle goes
// straight to the finish step, which writes the output register. A sample
// during a run goes one bit per cycle through the shift-add speed-map
// multipliers, then the restoring dividers, then, after the error step, the
// shift-add gain multiplier before the finish step; the distance multiply runs
// alongside the speed-map multipliers. A new beat is taken once the previous
// one has been written to the output register, which may still be waiting on
// out_ready.
`timescale 1ns / 1ps
`default_nettype none

module straight_drive_wheel_sync
    import sdws_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire sdws_req_t             in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output sdws_res_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [DUTY_INT_W-1:0] duty_min_reg, duty_min_next;
    logic [DUTY_INT_W-1:0] duty_max_reg, duty_max_next;
    logic [SPEED_W-1:0]    r_low_reg, r_low_next;
    logic [SPEED_W-1:0]    r_high_reg, r_high_next;
    logic [SPEED_W-1:0]    l_low_reg, l_low_next;
    logic [SPEED_W-1:0]    l_high_reg, l_high_next;
    logic [GAIN_W-1:0]     gain_reg, gain_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;

    // control and run state
    sdws_state_t          state_reg, state_next;
    sdws_kind_t           kind_reg, kind_next;
    logic                 running_reg, running_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DCNT_W-1:0]    dcnt_reg, dcnt_next;
    logic [DUTY_W-1:0]    acc_r_reg, acc_r_next;
    logic [DUTY_W-1:0]    acc_l_reg, acc_l_next;
    logic [DISTANCE_BITS-1:0] trav_reg, trav_next;
    logic [TARGET_W-1:0]  target_reg, target_next;

    // serial lanes
    logic [PROD_W-1:0]    p_r_reg, p_r_next;
    logic [PROD_W-1:0]    p_l_reg, p_l_next;
    logic [SPEED_W-1:0]   a_r_reg, a_r_next;
    logic [SPEED_W-1:0]   a_l_reg, a_l_next;
    logic [SPEED_W-1:0]   den_r_reg, den_r_next;
    logic [SPEED_W-1:0]   den_l_reg, den_l_next;
    logic                 r_lo_reg, r_lo_next;
    logic                 r_hi_reg, r_hi_next;
    logic                 l_lo_reg, l_lo_next;
    logic                 l_hi_reg, l_hi_next;
    logic                 err_neg_reg, err_neg_next;
    logic [DPROD_W-1:0]   p_d_reg, p_d_next;
    logic [DSUM_W-1:0]    a_d_reg, a_d_next;
    sdws_res_t            out_reg, out_next;

    // shift-add multiply: multiplier in the low bits, product grows from the top
    function automatic logic [PROD_W-1:0] mul_step(input logic [PROD_W-1:0] p,
                                                   input logic [SPEED_W-1:0] a);
        logic [SPEED_W:0] s;
        s = {1'b0, p[PROD_W-1:DUTY_W]} + (p[0] ? {1'b0, a} : '0);
        return {s, p[DUTY_W-1:1]};
    endfunction

    // restoring divide in place: remainder on top, quotient shifts in below
    function automatic logic [PROD_W-1:0] div_step(input logic [PROD_W-1:0] p,
                                                   input logic [SPEED_W-1:0] den);
        logic [SPEED_W:0]   t;
        logic [SPEED_W:0]   d;
        logic               ge;
        logic [SPEED_W-1:0] r;
        t  = {p[PROD_W-1:DUTY_W], p[DUTY_W-1]};
        d  = t - {1'b0, den};
        ge = (t >= {1'b0, den});
        r  = ge ? d[SPEED_W-1:0] : t[SPEED_W-1:0];
        return {r, p[DUTY_W-2:0], ge};
    endfunction

    function automatic logic [DPROD_W-1:0] dmul_step(input logic [DPROD_W-1:0] p,
                                                     input logic [DSUM_W-1:0] a);
        logic [DSUM_W:0] s;
        s = {1'b0, p[DPROD_W-1:PERIOD_W]} + (p[0] ? {1'b0, a} : '0);
        return {s, p[PERIOD_W-1:1]};
    endfunction

    function automatic logic [DUTY_W-1:0] lane_duty(input logic lo, input logic hi,
                                                    input logic [DUTY_W-1:0] q,
                                                    input logic [DUTY_W-1:0] dmin,
                                                    input logic [DUTY_W-1:0] dmax,
                                                    input logic neg);
        logic [DUTY_W-1:0] d;
        if (lo)
            d = dmin;
        else if (hi)
            d = dmax;
        else if (neg)
            d = dmin - q;
        else
            d = dmin + q;
        return d;
    endfunction

    // upper limit first, then lower
    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [ACC_X_W-1:0] x,
                                                     input logic [DUTY_W-1:0] dmin,
                                                     input logic [DUTY_W-1:0] dmax);
        logic signed [ACC_X_W-1:0] lo_x;
        logic signed [ACC_X_W-1:0] hi_x;
        logic signed [ACC_X_W-1:0] t;
        lo_x = $signed(ACC_X_W'(dmin));
        hi_x = $signed(ACC_X_W'(dmax));
        t = (x > hi_x) ? hi_x : x;
        t = (t < lo_x) ? lo_x : t;
        return t[DUTY_W-1:0];
    endfunction

    // shared datapath terms
    logic [DUTY_W-1:0]     dmin_f, dmax_f, mag;
    logic [DUTY_INT_W-1:0] mag_int;
    logic                  span_neg;
    logic [TARGET_W-1:0]   target_mm;

    assign span_neg  = (duty_max_reg < duty_min_reg);
    assign mag_int   = span_neg ? (duty_min_reg - duty_max_reg) : (duty_max_reg - duty_min_reg);
    assign mag       = {mag_int, {DUTY_FRAC_BITS{1'b0}}};
    assign dmin_f    = {duty_min_reg, {DUTY_FRAC_BITS{1'b0}}};
    assign dmax_f    = {duty_max_reg, {DUTY_FRAC_BITS{1'b0}}};
    assign target_mm = TARGET_W'(in_data.target_cm) * TARGET_W'(MM_PER_CM)
                     + TARGET_W'(TARGET_OFFSET_MM);

    // duty difference after the divide
    logic [DUTY_W-1:0] duty_r, duty_l, emag;
    logic [DUTY_W:0]   diff, diff_abs;

    assign duty_r   = lane_duty(r_lo_reg, r_hi_reg, p_r_reg[DUTY_W-1:0], dmin_f, dmax_f,
                                span_neg);
    assign duty_l   = lane_duty(l_lo_reg, l_hi_reg, p_l_reg[DUTY_W-1:0], dmin_f, dmax_f,
                                span_neg);
    assign diff     = {1'b0, duty_r} - {1'b0, duty_l};
    assign diff_abs = diff[DUTY_W] ? (~diff + 1'b1) : diff;
    assign emag     = diff_abs[DUTY_W-1:0];

    // correction and distance update at the end of a sample
    logic [CORR_W-1:0]         corr_mag;
    logic signed [ACC_X_W-1:0] corr_x, ar_x, al_x, r_raw, l_raw;
    logic [DUTY_W-1:0]         acc_r_new, acc_l_new;
    logic [STEP_W-1:0]         step;
    logic [DISTANCE_BITS:0]    trav_sum;
    logic [DISTANCE_BITS-1:0]  trav_sat, trav_out, mm_wide;
    logic [GOAL_W-1:0]         goal;
    logic                      hit;
    logic [MM_W-1:0]           mm;

    assign corr_mag  = p_r_reg[PROD_W-1:GAIN_FRAC];
    assign corr_x    = $signed(ACC_X_W'(corr_mag));
    assign ar_x      = $signed(ACC_X_W'(acc_r_reg));
    assign al_x      = $signed(ACC_X_W'(acc_l_reg));
    assign r_raw     = err_neg_reg ? (ar_x + corr_x) : (ar_x - corr_x);
    assign l_raw     = err_neg_reg ? (al_x - corr_x) : (al_x + corr_x);
    assign acc_r_new = clamp_duty(r_raw, dmin_f, dmax_f);
    assign acc_l_new = clamp_duty(l_raw, dmin_f, dmax_f);

    assign step     = p_d_reg[DPROD_W-1:STEP_SHIFT];
    assign trav_sum = {1'b0, trav_reg} + (DISTANCE_BITS + 1)'(step);
    assign trav_sat = trav_sum[DISTANCE_BITS] ? '1 : trav_sum[DISTANCE_BITS-1:0];
    assign goal     = {target_reg, {DIST_FRAC{1'b0}}};
    // a goal past the distance ceiling is met once the distance saturates
    assign hit      = (CMP_W'(trav_sat) >= CMP_W'(goal)) || (trav_sat == '1);
    assign trav_out = (kind_reg == KIND_RUN) ? trav_sat : trav_reg;
    assign mm_wide  = trav_out >> DIST_FRAC;
    assign mm       = (mm_wide > DISTANCE_BITS'({MM_W{1'b1}})) ? {MM_W{1'b1}}
                                                              : mm_wide[MM_W-1:0];

    logic cnt_last;
    assign cnt_last = (cnt_reg == CNT_W'(DUTY_W - 1));

    always_comb
    begin
        duty_min_next  = duty_min_reg;
        duty_max_next  = duty_max_reg;
        r_low_next     = r_low_reg;
        r_high_next    = r_high_reg;
        l_low_next     = l_low_reg;
        l_high_next    = l_high_reg;
        gain_next      = gain_reg;
        period_next    = period_reg;
        state_next     = state_reg;
        kind_next      = kind_reg;
        running_next   = running_reg;
        out_valid_next = out_valid_reg;
        cnt_next       = cnt_reg;
        dcnt_next      = dcnt_reg;
        acc_r_next     = acc_r_reg;
        acc_l_next     = acc_l_reg;
        trav_next      = trav_reg;
        target_next    = target_reg;
        p_r_next       = p_r_reg;
        p_l_next       = p_l_reg;
        a_r_next       = a_r_reg;
        a_l_next       = a_l_reg;
        den_r_next     = den_r_reg;
        den_l_next     = den_l_reg;
        r_lo_next      = r_lo_reg;
        r_hi_next      = r_hi_reg;
        l_lo_next      = l_lo_reg;
        l_hi_next      = l_hi_reg;
        err_neg_next   = err_neg_reg;
        p_d_next       = p_d_reg;
        a_d_next       = a_d_reg;
        out_next       = out_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DUTY_MIN:         duty_min_next = cfg_data[DUTY_INT_W-1:0];
                REG_DUTY_MAX:         duty_max_next = cfg_data[DUTY_INT_W-1:0];
                REG_RIGHT_SPEED_LOW:  r_low_next    = cfg_data[SPEED_W-1:0];
                REG_RIGHT_SPEED_HIGH: r_high_next   = cfg_data[SPEED_W-1:0];
                REG_LEFT_SPEED_LOW:   l_low_next    = cfg_data[SPEED_W-1:0];
                REG_LEFT_SPEED_HIGH:  l_high_next   = cfg_data[SPEED_W-1:0];
                REG_CORRECTION_GAIN:  gain_next     = cfg_data[GAIN_W-1:0];
                REG_SAMPLE_PERIOD:    period_next   = cfg_data[PERIOD_W-1:0];
                default:              duty_min_next = duty_min_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        // distance multiply runs on its own count during the mul phase
        if (dcnt_reg != '0)
        begin
            p_d_next  = dmul_step(p_d_reg, a_d_reg);
            dcnt_next = dcnt_reg - 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!in_data.req_type)
                    begin
                        target_next  = target_mm;
                        trav_next    = '0;
                        acc_r_next   = dmin_f;
                        acc_l_next   = dmin_f;
                        running_next = 1'b1;
                        kind_next    = KIND_START;
                        state_next   = ST_FIN;
                    end
                    else if (running_reg)
                    begin
                        a_r_next   = in_data.velocity_right - r_low_reg;
                        a_l_next   = in_data.velocity_left - l_low_reg;
                        den_r_next = r_high_reg - r_low_reg;
                        den_l_next = l_high_reg - l_low_reg;
                        r_lo_next  = (in_data.velocity_right <= r_low_reg);
                        r_hi_next  = (in_data.velocity_right >= r_high_reg);
                        l_lo_next  = (in_data.velocity_left <= l_low_reg);
                        l_hi_next  = (in_data.velocity_left >= l_high_reg);
                        p_r_next   = {{SPEED_W{1'b0}}, mag};
                        p_l_next   = {{SPEED_W{1'b0}}, mag};
                        a_d_next   = {1'b0, in_data.velocity_right}
                                   + {1'b0, in_data.velocity_left};
                        p_d_next   = {{DSUM_W{1'b0}}, period_reg};
                        dcnt_next  = DCNT_W'(PERIOD_W);
                        cnt_next   = '0;
                        kind_next  = KIND_RUN;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        kind_next  = KIND_IGNORE;
                        state_next = ST_FIN;
                    end
                end
            end

            ST_MUL:
            begin
                p_r_next = mul_step(p_r_reg, a_r_reg);
                p_l_next = mul_step(p_l_reg, a_l_reg);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                p_r_next = div_step(p_r_reg, den_r_reg);
                p_l_next = div_step(p_l_reg, den_l_reg);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_ERR;
                end
            end

            ST_ERR:
            begin
                p_r_next     = {{SPEED_W{1'b0}}, emag};
                a_r_next     = gain_reg;
                err_neg_next = diff[DUTY_W];
                cnt_next     = '0;
                state_next   = ST_GAIN;
            end

            ST_GAIN:
            begin
                p_r_next = mul_step(p_r_reg, a_r_reg);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.duty_left   = '0;
                    out_next.duty_right  = '0;
                    out_next.moving      = running_reg;
                    out_next.done_res    = 1'b0;
                    out_next.distance_mm = mm;
                    if (kind_reg == KIND_RUN)
                    begin
                        acc_r_next = acc_r_new;
                        acc_l_next = acc_l_new;
                        trav_next  = trav_sat;
                        if (hit)
                        begin
                            running_next      = 1'b0;
                            out_next.moving   = 1'b0;
                            out_next.done_res = 1'b1;
                        end
                        else
                        begin
                            out_next.duty_left  = acc_l_new[DUTY_W-1:DUTY_FRAC_BITS];
                            out_next.duty_right = acc_r_new[DUTY_W-1:DUTY_FRAC_BITS];
                        end
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_min_reg  <= RST_DUTY_MIN;
            duty_max_reg  <= RST_DUTY_MAX;
            r_low_reg     <= RST_SPEED_LOW;
            r_high_reg    <= RST_SPEED_HIGH;
            l_low_reg     <= RST_SPEED_LOW;
            l_high_reg    <= RST_SPEED_HIGH;
            gain_reg      <= RST_GAIN;
            period_reg    <= RST_PERIOD;
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_IGNORE;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            dcnt_reg      <= '0;
            acc_r_reg     <= '0;
            acc_l_reg     <= '0;
            trav_reg      <= '0;
            target_reg    <= '0;
        end
        else
        begin
            duty_min_reg  <= duty_min_next;
            duty_max_reg  <= duty_max_next;
            r_low_reg     <= r_low_next;
            r_high_reg    <= r_high_next;
            l_low_reg     <= l_low_next;
            l_high_reg    <= l_high_next;
            gain_reg      <= gain_next;
            period_reg    <= period_next;
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            dcnt_reg      <= dcnt_next;
            acc_r_reg     <= acc_r_next;
            acc_l_reg     <= acc_l_next;
            trav_reg      <= trav_next;
            target_reg    <= target_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_r_reg     <= p_r_next;
        p_l_reg     <= p_l_next;
        a_r_reg     <= a_r_next;
        a_l_reg     <= a_l_next;
        den_r_reg   <= den_r_next;
        den_l_reg   <= den_l_next;
        r_lo_reg    <= r_lo_next;
        r_hi_reg    <= r_hi_next;
        l_lo_reg    <= l_lo_next;
        l_hi_reg    <= l_hi_next;
        err_neg_reg <= err_neg_next;
        p_d_reg     <= p_d_next;
        a_d_reg     <= a_d_next;
        out_reg     <= out_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // busy right after taking a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted on consecutive cycles");

    // a finished run never reports itself as still moving
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.done_res) |-> !out_data.moving)
        else $error("done result still flagged as moving");

    // remainder stays below the divisor for an in-range lane
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && !r_lo_reg && !r_hi_reg)
            |-> (p_r_reg[PROD_W-1:DUTY_W] < den_r_reg))
        else $error("right lane divider remainder out of range");

    // results only come from the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result beat raised outside the finish step");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for straight_drive_wheel_sync. A short table of
// directed beats runs under reset settings, then random drive runs (start,
// samples until the target is reached or the run is cut) under a series of
// register settings. Every result beat is checked against a software copy
// of the duty balancing and distance tracking, or for some table rows against a fixed expected result.
// ----------------------------------------------------------------------------

module tb_top;
    import sdws_pkg::*;

    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam int RAND_ITEMS   = 650;
    localparam int PHASE_ITEMS  = 80;
    localparam int RUN_CAP      = 30;
    localparam int LONG_RUN_CAP = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int N_ROWS       = 24;

    localparam longint DIST_TOP = (longint'(1) << DISTANCE_BITS) - 1;
    localparam longint MM_TOP   = (longint'(1) << MM_W) - 1;

    typedef struct packed {
        sdws_req_t req;
        logic      typed;
        sdws_res_t res;
    } row_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    sdws_req_t             in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    sdws_res_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // register copies
    logic [DUTY_INT_W-1:0] min_duty    = RST_DUTY_MIN;
    logic [DUTY_INT_W-1:0] max_duty    = RST_DUTY_MAX;
    logic [SPEED_W-1:0]    r_spd_lo    = RST_SPEED_LOW;
    logic [SPEED_W-1:0]    r_spd_hi    = RST_SPEED_HIGH;
    logic [SPEED_W-1:0]    l_spd_lo    = RST_SPEED_LOW;
    logic [SPEED_W-1:0]    l_spd_hi    = RST_SPEED_HIGH;
    logic [GAIN_W-1:0]     kp_gain     = RST_GAIN;
    logic [PERIOD_W-1:0]   tick_period = RST_PERIOD;

    // run state
    logic                     run_on   = 1'b0;
    logic [DUTY_W-1:0]        r_acc    = '0;
    logic [DUTY_W-1:0]        l_acc    = '0;
    logic [DISTANCE_BITS-1:0] dist_q12 = '0;
    logic [TARGET_W-1:0]      goal_mm  = '0;

    logic [CFG_DATA_W-1:0] reg_plan [8];
    row_t                  plan [N_ROWS];
    sdws_res_t             pending [$];

    int          fed       = 0;
    int          bad_cnt   = 0;
    int          seen      = 0;
    int          hold_asks = 0;
    bit          calm      = 1'b0;
    int unsigned cycles    = 0;

    straight_drive_wheel_sync uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint speed_duty(longint v, longint lo, longint hi);
        longint dmin, dmax, mag, q;
        dmin = longint'(min_duty) << DUTY_FRAC_BITS;
        dmax = longint'(max_duty) << DUTY_FRAC_BITS;
        if (v <= lo) return dmin;
        if (v >= hi) return dmax;
        mag = (dmax >= dmin) ? dmax - dmin : dmin - dmax;
        q   = ((v - lo) * mag) / (hi - lo);
        return (dmax < dmin) ? dmin - q : dmin + q;
    endfunction

    // upper limit first, so an inverted range lands on duty_min
    function automatic logic [DUTY_W-1:0] clamp_duty(longint d);
        longint dmin, dmax;
        dmin = longint'(min_duty) << DUTY_FRAC_BITS;
        dmax = longint'(max_duty) << DUTY_FRAC_BITS;
        if (d > dmax) d = dmax;
        if (d < dmin) d = dmin;
        return DUTY_W'(d);
    endfunction

    function automatic sdws_res_t wheel_step(sdws_req_t r);
        sdws_res_t res;
        longint    err, emag, corr, adv, sum, goal;
        res = '0;
        if (r.req_type == REQ_START)
        begin
            goal_mm  = TARGET_W'(longint'(r.target_cm) * MM_PER_CM + TARGET_OFFSET_MM);
            dist_q12 = '0;
            r_acc    = {min_duty, {DUTY_FRAC_BITS{1'b0}}};
            l_acc    = r_acc;
            run_on   = 1'b1;
        end
        else if (run_on)
        begin
            err  = speed_duty(r.velocity_right, r_spd_lo, r_spd_hi)
                 - speed_duty(r.velocity_left, l_spd_lo, l_spd_hi);
            emag = (err < 0) ? -err : err;
            corr = (longint'(kp_gain) * emag) >>> GAIN_FRAC;
            if (err < 0) corr = -corr;
            r_acc = clamp_duty(longint'(r_acc) - corr);
            l_acc = clamp_duty(longint'(l_acc) + corr);
            res.duty_right = r_acc[DUTY_W-1 -: DUTY_INT_W];
            res.duty_left  = l_acc[DUTY_W-1 -: DUTY_INT_W];

            // mean speed times period, Q.20 halved down to Q.12 mm
            adv = ((longint'(r.velocity_right) + longint'(r.velocity_left))
                  * longint'(tick_period)) >>> STEP_SHIFT;
            sum = longint'(dist_q12) + adv;
            dist_q12 = (sum > DIST_TOP) ? DISTANCE_BITS'(DIST_TOP) : DISTANCE_BITS'(sum);

            goal = longint'(goal_mm) << DIST_FRAC;
            if (goal > DIST_TOP) goal = DIST_TOP;
            if (longint'(dist_q12) >= goal)
            begin
                run_on         = 1'b0;
                res.done_res   = 1'b1;
                res.duty_left  = '0;
                res.duty_right = '0;
            end
        end
        res.moving = run_on;
        sum = longint'(dist_q12) >>> DIST_FRAC;
        if (sum > MM_TOP) sum = MM_TOP;
        res.distance_mm = MM_W'(sum);
        return res;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        case (idx)
            REG_DUTY_MIN:         min_duty    = v[DUTY_INT_W-1:0];
            REG_DUTY_MAX:         max_duty    = v[DUTY_INT_W-1:0];
            REG_RIGHT_SPEED_LOW:  r_spd_lo    = v;
            REG_RIGHT_SPEED_HIGH: r_spd_hi    = v;
            REG_LEFT_SPEED_LOW:   l_spd_lo    = v;
            REG_LEFT_SPEED_HIGH:  l_spd_hi    = v;
            REG_CORRECTION_GAIN:  kp_gain     = v;
            REG_SAMPLE_PERIOD:    tick_period = v;
            default: ;
        endcase
    endfunction

    function automatic sdws_req_t mk_req(logic kind, logic [TCM_W-1:0] tcm,
                                         logic [SPEED_W-1:0] vr, logic [SPEED_W-1:0] vl);
        sdws_req_t r;
        r.req_type       = kind;
        r.target_cm      = tcm;
        r.velocity_right = vr;
        r.velocity_left  = vl;
        return r;
    endfunction

    function automatic row_t row(logic kind, logic [TCM_W-1:0] tcm,
                                 logic [SPEED_W-1:0] vr, logic [SPEED_W-1:0] vl);
        row_t x;
        x.req   = mk_req(kind, tcm, vr, vl);
        x.typed = 1'b0;
        x.res   = '0;
        return x;
    endfunction

    // duties, done and distance all zero; only moving differs
    function automatic row_t row_zero(logic kind, logic [TCM_W-1:0] tcm,
                                      logic [SPEED_W-1:0] vr, logic [SPEED_W-1:0] vl,
                                      logic mv);
        row_t x;
        x.req        = mk_req(kind, tcm, vr, vl);
        x.typed      = 1'b1;
        x.res        = '0;
        x.res.moving = mv;
        return x;
    endfunction

    // duty registers get junk in the upper byte, which must be dropped
    function automatic logic [CFG_DATA_W-1:0] duty_word(logic [DUTY_INT_W-1:0] d);
        return {8'($urandom), d};
    endfunction

    function automatic logic [SPEED_W-1:0] pick_speed(logic [SPEED_W-1:0] lo,
                                                      logic [SPEED_W-1:0] hi);
        int a, b;
        a = (lo < hi) ? int'(lo) : int'(hi);
        b = (lo < hi) ? int'(hi) : int'(lo);
        case ($urandom_range(0, 9))
            0, 1, 2: return SPEED_W'($urandom);
            3:       return lo;
            4:       return hi;
            5:       return lo + 1'b1;
            6:       return hi - 1'b1;
            default: return SPEED_W'($urandom_range(a, b));
        endcase
    endfunction

    function automatic logic [TCM_W-1:0] pick_target();
        case ($urandom_range(0, 19))
            0:          return '1;
            1, 2, 3:    return TCM_W'($urandom);
            4, 5, 6, 7: return TCM_W'($urandom_range(16, 200));
            default:    return TCM_W'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic void plan_phase(int ph);
        case (ph)
            0:
            begin
                reg_plan[REG_DUTY_MIN]         = duty_word(8'd0);
                reg_plan[REG_DUTY_MAX]         = duty_word(8'd255);
                reg_plan[REG_RIGHT_SPEED_LOW]  = 16'd0;
                reg_plan[REG_RIGHT_SPEED_HIGH] = 16'hFFFF;
                reg_plan[REG_LEFT_SPEED_LOW]   = 16'd0;
                reg_plan[REG_LEFT_SPEED_HIGH]  = 16'hFFFF;
                reg_plan[REG_CORRECTION_GAIN]  = 16'hFFFF;
                reg_plan[REG_SAMPLE_PERIOD]    = 16'hFFFF;
            end
            1:
            begin
                // inverted duty range, empty and inverted speed ranges
                reg_plan[REG_DUTY_MIN]         = duty_word(8'd200);
                reg_plan[REG_DUTY_MAX]         = duty_word(8'd50);
                reg_plan[REG_RIGHT_SPEED_LOW]  = 16'd9000;
                reg_plan[REG_RIGHT_SPEED_HIGH] = 16'd9000;
                reg_plan[REG_LEFT_SPEED_LOW]   = 16'd12000;
                reg_plan[REG_LEFT_SPEED_HIGH]  = 16'd3000;
                reg_plan[REG_CORRECTION_GAIN]  = 16'd0;
                reg_plan[REG_SAMPLE_PERIOD]    = 16'd1;
            end
            2:
            begin
                reg_plan[REG_DUTY_MIN]         = duty_word(8'd255);
                reg_plan[REG_DUTY_MAX]         = duty_word(8'd255);
                reg_plan[REG_RIGHT_SPEED_LOW]  = 16'd0;
                reg_plan[REG_RIGHT_SPEED_HIGH] = 16'd1;
                reg_plan[REG_LEFT_SPEED_LOW]   = 16'hFFFF;
                reg_plan[REG_LEFT_SPEED_HIGH]  = 16'hFFFF;
                reg_plan[REG_CORRECTION_GAIN]  = 16'd4096;
                reg_plan[REG_SAMPLE_PERIOD]    = 16'd20000;
            end
            3:
            begin
                reg_plan[REG_DUTY_MIN]         = duty_word(8'd0);
                reg_plan[REG_DUTY_MAX]         = duty_word(8'd0);
                reg_plan[REG_RIGHT_SPEED_LOW]  = 16'd100;
                reg_plan[REG_RIGHT_SPEED_HIGH] = 16'd40000;
                reg_plan[REG_LEFT_SPEED_LOW]   = 16'd0;
                reg_plan[REG_LEFT_SPEED_HIGH]  = 16'd0;
                reg_plan[REG_CORRECTION_GAIN]  = 16'd12345;
                reg_plan[REG_SAMPLE_PERIOD]    = 16'hFFFF;
            end
            7:
            begin
                reg_plan[REG_DUTY_MIN]         = duty_word(RST_DUTY_MIN);
                reg_plan[REG_DUTY_MAX]         = duty_word(RST_DUTY_MAX);
                reg_plan[REG_RIGHT_SPEED_LOW]  = RST_SPEED_LOW;
                reg_plan[REG_RIGHT_SPEED_HIGH] = RST_SPEED_HIGH;
                reg_plan[REG_LEFT_SPEED_LOW]   = RST_SPEED_LOW;
                reg_plan[REG_LEFT_SPEED_HIGH]  = RST_SPEED_HIGH;
                reg_plan[REG_CORRECTION_GAIN]  = RST_GAIN;
                reg_plan[REG_SAMPLE_PERIOD]    = RST_PERIOD;
            end
            default:
            begin
                reg_plan[REG_DUTY_MIN]         = duty_word(8'($urandom_range(0, 120)));
                reg_plan[REG_DUTY_MAX]         = duty_word(8'($urandom_range(100, 255)));
                reg_plan[REG_RIGHT_SPEED_LOW]  = 16'($urandom_range(0, 4000));
                reg_plan[REG_RIGHT_SPEED_HIGH] = reg_plan[REG_RIGHT_SPEED_LOW]
                                               + 16'($urandom_range(1, 30000));
                reg_plan[REG_LEFT_SPEED_LOW]   = 16'($urandom_range(0, 4000));
                reg_plan[REG_LEFT_SPEED_HIGH]  = reg_plan[REG_LEFT_SPEED_LOW]
                                               + 16'($urandom_range(1, 30000));
                reg_plan[REG_CORRECTION_GAIN]  = 16'($urandom_range(0, 16384));
                reg_plan[REG_SAMPLE_PERIOD]    = 16'($urandom_range(500, 65535));
            end
        endcase
    endfunction

    task automatic load_regs();
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= reg_plan[i];
            @(posedge clk);
            apply_reg(CFG_IDX_W'(i), reg_plan[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // offer one beat, then predict it once it is taken
    task automatic send(input sdws_req_t r, input logic typed, input sdws_res_t typed_res);
        sdws_res_t want;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (r.req_type == REQ_START || run_on) fed = fed + 1;
        want = wheel_step(r);
        pending.push_back(typed ? typed_res : want);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
    endtask

    // one start, then samples until the run ends, is cut short or hits the cap, maybe one late sample
    task automatic drive_run();
        int n;
        n = 0;
        send(mk_req(REQ_START, pick_target(), SPEED_W'($urandom), SPEED_W'($urandom)),
             1'b0, '0);
        while (run_on && n < RUN_CAP && $urandom_range(0, 24) != 0)
        begin
            send(mk_req(REQ_SAMPLE, TCM_W'($urandom), pick_speed(r_spd_lo, r_spd_hi),
                        pick_speed(l_spd_lo, l_spd_hi)), 1'b0, '0);
            n++;
        end
        if (!run_on && $urandom_range(0, 4) == 0)
            send(mk_req(REQ_SAMPLE, TCM_W'($urandom), SPEED_W'($urandom),
                        SPEED_W'($urandom)), 1'b0, '0);
    endtask

    initial
    begin : stim
        int ph, n, phase_end;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        plan = '{
            row_zero(REQ_SAMPLE, 14'd0,      16'hFFFF, 16'hFFFF, 1'b0),
            row_zero(REQ_SAMPLE, 14'h3FFF,   16'd0,    16'd0,    1'b0),
            row_zero(REQ_START,  14'd0,      16'd0,    16'd0,    1'b1),
            row_zero(REQ_SAMPLE, 14'd0,      16'd0,    16'd0,    1'b1),
            row(REQ_SAMPLE,      14'd0,      16'd16000, 16'd0),
            row(REQ_SAMPLE,      14'd0,      16'd0,    16'd16000),
            row(REQ_SAMPLE,      14'd0,      16'd1234, 16'd4321),
            row_zero(REQ_START,  14'h3FFF,   16'hFFFF, 16'hFFFF, 1'b1),
            row(REQ_SAMPLE,      14'd0,      16'hFFFF, 16'hFFFF),
            row(REQ_SAMPLE,      14'd0,      16'hFFFF, 16'd0),
            row(REQ_SAMPLE,      14'd0,      16'd0,    16'hFFFF),
            row_zero(REQ_START,  14'd1,      16'd0,    16'd0,    1'b1),
            row(REQ_SAMPLE,      14'd0,      16'd1,    16'd0),
            row(REQ_SAMPLE,      14'd0,      16'd0,    16'd1),
            row(REQ_SAMPLE,      14'd0,      16'd8000, 16'd8000),
            row(REQ_SAMPLE,      14'd0,      16'd16001, 16'd15999),
            row(REQ_SAMPLE,      14'd0,      16'hFFFF, 16'hFFFF),
            row(REQ_SAMPLE,      14'd0,      16'd0,    16'hFFFF),
            row_zero(REQ_START,  14'h2AAA,   16'h5555, 16'hAAAA, 1'b1),
            row(REQ_SAMPLE,      14'h1555,   16'hAAAA, 16'h5555),
            row_zero(REQ_START,  14'h1555,   16'hAAAA, 16'h5555, 1'b1),
            row(REQ_SAMPLE,      14'h2AAA,   16'h5555, 16'hAAAA),
            row_zero(REQ_START,  14'd0,      16'd0,    16'd0,    1'b1),
            row(REQ_SAMPLE,      14'd0,      16'hFFFF, 16'hFFFF)
        };
        foreach (plan[k])
            send(plan[k].req, plan[k].typed, plan[k].res);

        fed = 0;
        ph  = 0;
        while (fed < RAND_ITEMS)
        begin
            settle();
            plan_phase(ph);
            load_regs();
            if (ph == 0)
            begin
                // output side holds off while a long run keeps coming
                hold_asks = hold_asks + 1;
                send(mk_req(REQ_START, '1, SPEED_W'($urandom), SPEED_W'($urandom)),
                     1'b0, '0);
                n = 0;
                while (run_on && n < LONG_RUN_CAP)
                begin
                    send(mk_req(REQ_SAMPLE, TCM_W'($urandom),
                                SPEED_W'($urandom_range(60000, 65535)),
                                SPEED_W'($urandom_range(60000, 65535))), 1'b0, '0);
                    n++;
                end
            end
            phase_end = fed + PHASE_ITEMS;
            while (fed < phase_end && fed < RAND_ITEMS)
            begin
                calm = (fed >= RAND_ITEMS * 85 / 100);
                drive_run();
            end
            ph++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_cnt == 0)
            $display("straight_drive_wheel_sync: match");
        else
            $display("straight_drive_wheel_sync: mismatch");
        $finish;
    end

    initial
    begin : rx_drive
        int stall_left, hold_seen;
        stall_left = 0;
        hold_seen  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_asks)
            begin
                hold_seen  = hold_asks;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 7);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        sdws_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = seen + 1;
            if (pending.size() == 0)
            begin
                bad_cnt = bad_cnt + 1;
                if (bad_cnt <= 10)
                    $display("beat %0d: result with nothing pending (L%0d R%0d mm %0d)",
                             seen, out_data.duty_left, out_data.duty_right,
                             out_data.distance_mm);
            end
            else
            begin
                want = pending.pop_front();
                if (out_data.duty_left   !== want.duty_left   ||
                    out_data.duty_right  !== want.duty_right  ||
                    out_data.moving      !== want.moving      ||
                    out_data.done_res    !== want.done_res    ||
                    out_data.distance_mm !== want.distance_mm)
                begin
                    bad_cnt = bad_cnt + 1;
                    if (bad_cnt <= 10)
                        $display("beat %0d: got L%0d R%0d mv%0d dn%0d mm%0d, want L%0d R%0d mv%0d dn%0d mm%0d",
                                 seen, out_data.duty_left, out_data.duty_right,
                                 out_data.moving, out_data.done_res, out_data.distance_mm,
                                 want.duty_left, want.duty_right, want.moving,
                                 want.done_res, want.distance_mm);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("straight_drive_wheel_sync: mismatch");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
hdl/sdws_pkg.sv
hdl/straight_drive_wheel_sync.sv
tb/tb_top.sv
